@@ design/ece_pkg.sv @@
// Shared types, fixed-point constants and the truncating multiply for the easing curve evaluator.
`default_nettype none
package ece_pkg;

	localparam int FRAC_BITS = 16;
	localparam int PROG_W    = 17;
	localparam int CURVE_W   = 4;
	localparam int OUT_W     = 18;
	localparam int FX_W      = FRAC_BITS + 6;
	localparam int SUM_W     = FX_W + 2;

	typedef logic signed [FX_W-1:0]  fx_t;
	typedef logic signed [SUM_W-1:0] sum_t;
	typedef logic [PROG_W-1:0]       prog_t;
	typedef logic [CURVE_W-1:0]      curve_t;
	typedef logic signed [OUT_W-1:0] eased_t;

	// curve codes
	localparam curve_t CRV_LINEAR     = 4'd0;
	localparam curve_t CRV_QUAD_IN    = 4'd1;
	localparam curve_t CRV_QUAD_OUT   = 4'd2;
	localparam curve_t CRV_QUAD_INOUT = 4'd3;
	localparam curve_t CRV_CUBE_IN    = 4'd4;
	localparam curve_t CRV_CUBE_OUT   = 4'd5;
	localparam curve_t CRV_CUBE_INOUT = 4'd6;
	localparam curve_t CRV_BACK_IN    = 4'd7;
	localparam curve_t CRV_BACK_OUT   = 4'd8;
	localparam curve_t CRV_BACK_INOUT = 4'd9;
	localparam curve_t CRV_BOUNCE_OUT = 4'd10;

	// final combine selection
	typedef enum logic [3:0] {
		MODE_T,
		MODE_P1,
		MODE_P1X2,
		MODE_P2,
		MODE_P2X4,
		MODE_P2H,
		MODE_P3MQ,
		MODE_P3PQ,
		MODE_BKLO,
		MODE_BKHI
	} mode_t;

	localparam longint ONE_L  = longint'(1) << FRAC_BITS;
	localparam longint C1_L   = ((longint'(170158) << FRAC_BITS) + 50000) / 100000;
	localparam longint C2_L   = ((longint'(25949095) << FRAC_BITS) + 5000000) / 10000000;
	localparam longint K_L    = ((longint'(121) << FRAC_BITS) + 8) / 16;
	localparam longint B4_L   = ((longint'(4) << FRAC_BITS) + 5) / 11;
	localparam longint B8_L   = ((longint'(8) << FRAC_BITS) + 5) / 11;
	localparam longint B10_L  = ((longint'(10) << FRAC_BITS) + 5) / 11;
	localparam longint M6_L   = ((longint'(6) << FRAC_BITS) + 5) / 11;
	localparam longint M9_L   = ((longint'(9) << FRAC_BITS) + 5) / 11;
	localparam longint M21_L  = ((longint'(21) << FRAC_BITS) + 11) / 22;
	localparam longint O34_L  = ((longint'(3) << FRAC_BITS) + 2) / 4;
	localparam longint O1516_L = ((longint'(15) << FRAC_BITS) + 8) / 16;
	localparam longint O6364_L = ((longint'(63) << FRAC_BITS) + 32) / 64;

	localparam fx_t FX_ZERO  = FX_W'(0);
	localparam fx_t FX_ONE   = FX_W'(ONE_L);
	localparam fx_t FX_HALF  = FX_W'(ONE_L / 2);
	localparam fx_t FX_TWO   = FX_W'(2 * ONE_L);
	localparam fx_t FX_FOUR  = FX_W'(4 * ONE_L);
	localparam fx_t FX_MONE  = FX_W'(-ONE_L);
	localparam fx_t FX_C1    = FX_W'(C1_L);
	localparam fx_t FX_C3    = FX_W'(C1_L + ONE_L);
	localparam fx_t FX_C2    = FX_W'(C2_L);
	localparam fx_t FX_C2P1  = FX_W'(C2_L + ONE_L);
	localparam fx_t FX_K     = FX_W'(K_L);
	localparam fx_t FX_B4    = FX_W'(B4_L);
	localparam fx_t FX_B8    = FX_W'(B8_L);
	localparam fx_t FX_B10   = FX_W'(B10_L);
	localparam fx_t FX_M6    = FX_W'(M6_L);
	localparam fx_t FX_M9    = FX_W'(M9_L);
	localparam fx_t FX_M21   = FX_W'(M21_L);
	localparam fx_t FX_O34   = FX_W'(O34_L);
	localparam fx_t FX_O1516 = FX_W'(O1516_L);
	localparam fx_t FX_O6364 = FX_W'(O6364_L);

	localparam prog_t PROG_ONE = PROG_W'(ONE_L);
	localparam sum_t  SUM_MAX  = SUM_W'((longint'(1) << (OUT_W - 1)) - 1);
	localparam sum_t  SUM_MIN  = SUM_W'(-(longint'(1) << (OUT_W - 1)));

	// product truncated toward minus infinity
	function automatic fx_t fmul(input fx_t a, input fx_t b);
		logic signed [2*FX_W-1:0] prod;
		logic signed [2*FX_W-1:0] shr;
		prod = a * b;
		shr  = prod >>> FRAC_BITS;
		return shr[FX_W-1:0];
	endfunction

	function automatic sum_t sx(input fx_t a);
		return {{(SUM_W-FX_W){a[FX_W-1]}}, a};
	endfunction

endpackage
`default_nettype wire

@@ design/easing_curve_evaluator_core.sv @@
// Pipelined fixed-point easing curve evaluator: operand setup, three multiply stages, combine.
//
//  channel | signals                          | beat
//  --------+----------------------------------+---------------------------
//  in      | in_valid in_ready progress curve | one progress value + code
//  out     | out_valid out_ready eased        | one eased value
//
// Five register stages (setup, three multiply stages, combine/saturate).
// One beat in and one beat out per cycle when out_ready stays high.
// Each stage holds while its successor is full and stalled; ready ripples back
// combinationally so a stall neither drops nor repeats a beat.
// arst_n clears the stage valid bits only.
`default_nettype none
module easing_curve_evaluator_core (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              in_valid,
	output logic                             in_ready,
	input  wire  [ece_pkg::PROG_W-1:0]       progress,
	input  wire  [ece_pkg::CURVE_W-1:0]      curve,
	output logic                             out_valid,
	input  wire                              out_ready,
	output logic signed [ece_pkg::OUT_W-1:0] eased
);
	import ece_pkg::*;

	logic en1, en2, en3, en4, en5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	prog_t t_clamp;
	fx_t   t_fx, a_d, b_d, b2_d, b3_d, cs_d, off_d, u_d;
	mode_t mode_d;
	logic  lower;

	fx_t   t_s1, a_s1, b_s1, b2_s1, b3_s1, cs_s1, off_s1;
	mode_t mode_s1;
	fx_t   t_s2, p1_s2, b2_s2, b3_s2, cs_s2, off_s2;
	mode_t mode_s2;
	fx_t   t_s3, p1_s3, p2_s3, q_s3, b3_s3, off_s3;
	mode_t mode_s3;
	fx_t   t_s4, p1_s4, p2_s4, p3_s4, q_s4, off_s4;
	mode_t mode_s4;
	sum_t  sum_d;
	eased_t eased_d, eased_s5;

	assign en5      = !v_s5 || out_ready;
	assign en4      = !v_s4 || en5;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;
	assign out_valid = v_s5;
	assign eased    = eased_s5;

	// operand setup
	always_comb begin
		t_clamp = (progress > PROG_ONE) ? PROG_ONE : progress;
		t_fx    = {{(FX_W-PROG_W){1'b0}}, t_clamp};
		lower   = t_fx < FX_HALF;
		u_d     = FX_ZERO;
		a_d     = t_fx;
		b_d     = t_fx;
		b2_d    = t_fx;
		b3_d    = t_fx;
		cs_d    = FX_C1;
		off_d   = FX_ZERO;
		mode_d  = MODE_T;
		unique case (curve)
			CRV_QUAD_IN: begin
				mode_d = MODE_P1;
			end
			CRV_QUAD_OUT: begin
				b_d    = FX_TWO - t_fx;
				mode_d = MODE_P1;
			end
			CRV_QUAD_INOUT: begin
				if (lower) begin
					mode_d = MODE_P1X2;
				end else begin
					a_d    = FX_FOUR - (t_fx <<< 1);
					off_d  = FX_MONE;
					mode_d = MODE_P1;
				end
			end
			CRV_CUBE_IN: begin
				mode_d = MODE_P2;
			end
			CRV_CUBE_OUT: begin
				u_d    = t_fx - FX_ONE;
				a_d    = u_d;
				b_d    = u_d;
				b2_d   = u_d;
				off_d  = FX_ONE;
				mode_d = MODE_P2;
			end
			CRV_CUBE_INOUT: begin
				if (lower) begin
					mode_d = MODE_P2X4;
				end else begin
					u_d    = (t_fx <<< 1) - FX_TWO;
					a_d    = u_d;
					b_d    = u_d;
					b2_d   = u_d;
					off_d  = FX_ONE;
					mode_d = MODE_P2H;
				end
			end
			CRV_BACK_IN: begin
				b3_d   = FX_C3;
				mode_d = MODE_P3MQ;
			end
			CRV_BACK_OUT: begin
				u_d    = t_fx - FX_ONE;
				a_d    = u_d;
				b_d    = u_d;
				b2_d   = u_d;
				b3_d   = FX_C3;
				off_d  = FX_ONE;
				mode_d = MODE_P3PQ;
			end
			CRV_BACK_INOUT: begin
				u_d    = lower ? (t_fx <<< 1) : ((t_fx <<< 1) - FX_TWO);
				a_d    = u_d;
				b_d    = u_d;
				b2_d   = FX_C2P1;
				b3_d   = u_d;
				cs_d   = FX_C2;
				off_d  = FX_TWO;
				mode_d = lower ? MODE_BKLO : MODE_BKHI;
			end
			CRV_BOUNCE_OUT: begin
				if (t_fx < FX_B4) begin
					u_d   = t_fx;
					off_d = FX_ZERO;
				end else if (t_fx < FX_B8) begin
					u_d   = t_fx - FX_M6;
					off_d = FX_O34;
				end else if (t_fx < FX_B10) begin
					u_d   = t_fx - FX_M9;
					off_d = FX_O1516;
				end else begin
					u_d   = t_fx - FX_M21;
					off_d = FX_O6364;
				end
				a_d    = FX_K;
				b_d    = u_d;
				b2_d   = u_d;
				mode_d = MODE_P2;
			end
			default: begin
				mode_d = MODE_T;
			end
		endcase
	end

	// combine and saturate
	always_comb begin
		case (mode_s4)
			MODE_P1:   sum_d = sx(p1_s4) + sx(off_s4);
			MODE_P1X2: sum_d = sx(p1_s4) <<< 1;
			MODE_P2:   sum_d = sx(p2_s4) + sx(off_s4);
			MODE_P2X4: sum_d = sx(p2_s4) <<< 2;
			MODE_P2H:  sum_d = (sx(p2_s4) >>> 1) + sx(off_s4);
			MODE_P3MQ: sum_d = sx(p3_s4) - sx(q_s4);
			MODE_P3PQ: sum_d = sx(p3_s4) + sx(q_s4) + sx(off_s4);
			MODE_BKLO: sum_d = (sx(p3_s4) - sx(q_s4)) >>> 1;
			MODE_BKHI: sum_d = (sx(p3_s4) + sx(q_s4) + sx(off_s4)) >>> 1;
			default:   sum_d = sx(t_s4);
		endcase
		if (sum_d > SUM_MAX) begin
			eased_d = SUM_MAX[OUT_W-1:0];
		end else if (sum_d < SUM_MIN) begin
			eased_d = SUM_MIN[OUT_W-1:0];
		end else begin
			eased_d = sum_d[OUT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
			if (en5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			t_s1    <= t_fx;
			a_s1    <= a_d;
			b_s1    <= b_d;
			b2_s1   <= b2_d;
			b3_s1   <= b3_d;
			cs_s1   <= cs_d;
			off_s1  <= off_d;
			mode_s1 <= mode_d;
		end
		if (en2) begin
			t_s2    <= t_s1;
			p1_s2   <= fmul(a_s1, b_s1);
			b2_s2   <= b2_s1;
			b3_s2   <= b3_s1;
			cs_s2   <= cs_s1;
			off_s2  <= off_s1;
			mode_s2 <= mode_s1;
		end
		if (en3) begin
			t_s3    <= t_s2;
			p1_s3   <= p1_s2;
			p2_s3   <= fmul(p1_s2, b2_s2);
			q_s3    <= fmul(cs_s2, p1_s2);
			b3_s3   <= b3_s2;
			off_s3  <= off_s2;
			mode_s3 <= mode_s2;
		end
		if (en4) begin
			t_s4    <= t_s3;
			p1_s4   <= p1_s3;
			p2_s4   <= p2_s3;
			p3_s4   <= fmul(p2_s3, b3_s3);
			q_s4    <= q_s3;
			off_s4  <= off_s3;
			mode_s4 <= mode_s3;
		end
		if (en5) begin
			eased_s5 <= eased_d;
		end
	end

endmodule
`default_nettype wire
